@@ src/wxps_pkg.sv @@
// shared types and constants for the water exchange pump sequencer
package wxps_pkg;

    localparam logic [31:0] COOLDOWN_MS    = 32'd60000;
    localparam logic [31:0] SETTLE_SAMPLES = 32'd3;
    localparam logic [31:0] MAX_AGE_MS     = 32'd5000;

    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_STOP        = 3'd1,
        CMD_FILL        = 3'd2,
        CMD_DRAIN       = 3'd3,
        CMD_EXCHANGE    = 3'd4,
        CMD_AUTO_ON     = 3'd5,
        CMD_AUTO_OFF    = 3'd6,
        CMD_CLEAR_FAULT = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED       = 4'd0,
        ST_NOT_CONFIGURED = 4'd1,
        ST_PUMPS_RUNNING  = 4'd2,
        ST_FAULT_LATCHED  = 4'd3,
        ST_RELAYS_ABSENT  = 4'd4,
        ST_UNSAFE_DUR     = 4'd5,
        ST_INVALID        = 4'd6,
        ST_BUSY           = 4'd7,
        ST_INTERLOCK      = 4'd8,
        ST_NONE           = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DRAIN = 3'd1,
        PH_FILL  = 3'd2,
        PH_DONE  = 3'd3,
        PH_FAULT = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        FC_NONE      = 2'd0,
        FC_INTERLOCK = 2'd1,
        FC_TIMEOUT   = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        CFG_PH_LOW      = 3'd0,
        CFG_PH_HIGH     = 3'd1,
        CFG_ORP_LOW     = 3'd2,
        CFG_ORP_HIGH    = 3'd3,
        CFG_TURB_HIGH   = 3'd4,
        CFG_AUTO_DRAIN  = 3'd5,
        CFG_AUTO_FILL   = 3'd6,
        CFG_PUMP_MAX    = 3'd7
    } cfg_idx_t;

endpackage

@@ src/water_exchange_pump_sequencer.sv @@
// Sequences a fill and a drain pump through idle, draining, refilling, complete and fault.
// Each request carries one command and returns exactly one result showing the status and the
// pump state after that command. A request is captured into an input register, evaluated
// against the sequencer state and the limit registers, and the result is held in an output
// register; a new request is taken every cycle unless the output register holds a result
// that m_tready does not take; the state update loop sets the rate. The user must write limit
// registers through the config port only while no request is in flight; the block does not enforce this.
module water_exchange_pump_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [wxps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wxps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // duration_ms, now_ms, relays_ready, ph_value, ph_ok, turbidity_value, turbidity_ok,
    // orp_value_mv, orp_ok, sample_count, sample_time_ms, zero pad
    input  logic [wxps_pkg::IN_DATA_W-1:0]       s_tdata,
    // command
    input  logic [wxps_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status, phase_now, fault_cause, fill_pump_on, drain_pump_on, auto_mode, zero pad
    output logic [wxps_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import wxps_pkg::*;

    // limit registers
    logic [10:0]        ph_low_reg, ph_high_reg;
    logic signed [11:0] orp_low_reg, orp_high_reg;
    logic [11:0]        turb_high_reg;
    logic [31:0]        auto_drain_reg, auto_fill_reg, pump_max_reg;

    // input stage
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic [IN_USER_W-1:0] in_user_reg;

    // output stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    fault_t      fault_reg, fault_next;
    logic        auto_reg, auto_next;
    logic        pending_reg, pending_next;
    logic        done_reg, done_next;
    logic        fill_reg, fill_next;
    logic        drain_reg, drain_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] refill_reg, refill_next;
    logic [31:0] last_done_reg, last_done_next;
    status_t     status;

    logic advance;

    // decoded request
    cmd_t               cmd;
    logic [31:0]        duration, now, sample_count, sample_time;
    logic               relays, ph_ok, turb_ok, orp_ok;
    logic [10:0]        ph_value;
    logic [11:0]        turb_value;
    logic signed [11:0] orp_value;

    logic [31:0] run_elapsed, done_elapsed, sample_age;
    logic running, max_hit, len_hit, cool_ok, fresh, settled, readings_ok;
    logic dur_ok, policy_ok, critical, auto_start;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cmd          = cmd_t'(in_user_reg);
    assign duration     = in_data_reg[31:0];
    assign now          = in_data_reg[63:32];
    assign relays       = in_data_reg[64];
    assign ph_value     = in_data_reg[75:65];
    assign ph_ok        = in_data_reg[76];
    assign turb_value   = in_data_reg[88:77];
    assign turb_ok      = in_data_reg[89];
    assign orp_value    = $signed(in_data_reg[101:90]);
    assign orp_ok       = in_data_reg[102];
    assign sample_count = in_data_reg[134:103];
    assign sample_time  = in_data_reg[166:135];

    assign run_elapsed  = now - start_reg;
    assign done_elapsed = now - last_done_reg;
    assign sample_age   = now - sample_time;

    assign running     = (phase_reg == PH_DRAIN) || (phase_reg == PH_FILL);
    assign max_hit     = run_elapsed >= pump_max_reg;
    assign len_hit     = run_elapsed >= length_reg;
    assign cool_ok     = !done_reg || (done_elapsed >= COOLDOWN_MS);
    assign fresh       = sample_age <= MAX_AGE_MS;
    assign settled     = sample_count >= SETTLE_SAMPLES;
    assign readings_ok = ph_ok && turb_ok && orp_ok;
    assign dur_ok      = (duration != 32'd0) && (duration <= pump_max_reg);

    assign policy_ok = relays
        && (auto_drain_reg != 32'd0) && (auto_drain_reg <= pump_max_reg)
        && (auto_fill_reg != 32'd0) && (auto_fill_reg <= pump_max_reg)
        && (COOLDOWN_MS != 32'd0)
        && (ph_low_reg < ph_high_reg)
        && (orp_low_reg < orp_high_reg)
        && (turb_high_reg != 12'd0);

    assign critical = (ph_value < ph_low_reg) || (ph_value > ph_high_reg)
        || (turb_value > turb_high_reg)
        || (orp_value < orp_low_reg) || (orp_value > orp_high_reg);

    assign auto_start = auto_reg && (phase_reg != PH_FAULT) && policy_ok && cool_ok
        && settled && fresh && readings_ok && critical;

    always_comb begin
        phase_next     = phase_reg;
        fault_next     = fault_reg;
        auto_next      = auto_reg;
        pending_next   = pending_reg;
        done_next      = done_reg;
        fill_next      = fill_reg;
        drain_next     = drain_reg;
        start_next     = start_reg;
        length_next    = length_reg;
        refill_next    = refill_reg;
        last_done_next = last_done_reg;
        status         = ST_ACCEPTED;
        case (cmd)
            CMD_TICK: begin
                status = ST_NONE;
                if (running) begin
                    if (!relays || (fill_reg && drain_reg)) begin
                        fill_next    = 1'b0;
                        drain_next   = 1'b0;
                        pending_next = 1'b0;
                        auto_next    = 1'b0;
                        phase_next   = PH_FAULT;
                        fault_next   = FC_INTERLOCK;
                    end else if (max_hit) begin
                        fill_next    = 1'b0;
                        drain_next   = 1'b0;
                        pending_next = 1'b0;
                        auto_next    = 1'b0;
                        phase_next   = PH_FAULT;
                        fault_next   = FC_TIMEOUT;
                    end else if (len_hit) begin
                        drain_next = 1'b0;
                        if (phase_reg == PH_DRAIN && pending_reg) begin
                            // exchange: drain done, start refill
                            phase_next   = PH_FILL;
                            pending_next = 1'b0;
                            start_next   = now;
                            length_next  = refill_reg;
                            fill_next    = 1'b1;
                        end else begin
                            fill_next      = 1'b0;
                            phase_next     = PH_DONE;
                            last_done_next = now;
                            done_next      = 1'b1;
                        end
                    end
                end else if (auto_start) begin
                    pending_next = 1'b1;
                    fill_next    = 1'b0;
                    drain_next   = 1'b1;
                    phase_next   = PH_DRAIN;
                    start_next   = now;
                    length_next  = auto_drain_reg;
                    refill_next  = auto_fill_reg;
                    auto_next    = 1'b1;
                end
            end
            CMD_STOP, CMD_AUTO_OFF: begin
                auto_next    = 1'b0;
                fill_next    = 1'b0;
                drain_next   = 1'b0;
                pending_next = 1'b0;
                if (phase_reg != PH_FAULT) begin
                    phase_next = PH_IDLE;
                end
            end
            CMD_FILL, CMD_DRAIN, CMD_EXCHANGE: begin
                if (phase_reg == PH_FAULT) begin
                    status = ST_FAULT_LATCHED;
                end else if (!relays) begin
                    status = ST_RELAYS_ABSENT;
                end else if (!dur_ok) begin
                    status = ST_UNSAFE_DUR;
                end else if (!auto_reg && running) begin
                    status = ST_BUSY;
                end else begin
                    auto_next    = 1'b0;
                    pending_next = (cmd == CMD_EXCHANGE);
                    fill_next    = (cmd == CMD_FILL);
                    drain_next   = (cmd != CMD_FILL);
                    phase_next   = (cmd == CMD_FILL) ? PH_FILL : PH_DRAIN;
                    start_next   = now;
                    length_next  = duration;
                    refill_next  = duration;
                end
            end
            CMD_AUTO_ON: begin
                if (!policy_ok) begin
                    status = ST_NOT_CONFIGURED;
                end else begin
                    fill_next    = 1'b0;
                    drain_next   = 1'b0;
                    pending_next = 1'b0;
                    auto_next    = 1'b1;
                    if (phase_reg != PH_FAULT) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_CLEAR_FAULT: begin
                if (fill_reg || drain_reg) begin
                    status = ST_PUMPS_RUNNING;
                end else begin
                    phase_next = PH_IDLE;
                    fault_next = FC_NONE;
                end
            end
            default: begin
                status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_low_reg     <= 11'd650;
            ph_high_reg    <= 11'd850;
            orp_low_reg    <= 12'sd200;
            orp_high_reg   <= 12'sd400;
            turb_high_reg  <= 12'd3000;
            auto_drain_reg <= 32'd0;
            auto_fill_reg  <= 32'd0;
            pump_max_reg   <= 32'd0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PH_LOW:     ph_low_reg     <= cfg_data[10:0];
                CFG_PH_HIGH:    ph_high_reg    <= cfg_data[10:0];
                CFG_ORP_LOW:    orp_low_reg    <= $signed(cfg_data[11:0]);
                CFG_ORP_HIGH:   orp_high_reg   <= $signed(cfg_data[11:0]);
                CFG_TURB_HIGH:  turb_high_reg  <= cfg_data[11:0];
                CFG_AUTO_DRAIN: auto_drain_reg <= cfg_data;
                CFG_AUTO_FILL:  auto_fill_reg  <= cfg_data;
                CFG_PUMP_MAX:   pump_max_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'd0, auto_next, drain_next, fill_next, fault_next,
                             phase_next, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            fault_reg     <= FC_NONE;
            auto_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            done_reg      <= 1'b0;
            fill_reg      <= 1'b0;
            drain_reg     <= 1'b0;
            start_reg     <= 32'd0;
            length_reg    <= 32'd0;
            refill_reg    <= 32'd0;
            last_done_reg <= 32'd0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            fault_reg     <= fault_next;
            auto_reg      <= auto_next;
            pending_reg   <= pending_next;
            done_reg      <= done_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            start_reg     <= start_next;
            length_reg    <= length_next;
            refill_reg    <= refill_next;
            last_done_reg <= last_done_next;
        end
    end

endmodule
